[rtl/wsrc_pkg.sv]
`default_nettype none

package wsrc_pkg;

  localparam int unsigned IDX_W      = 10;
  localparam int unsigned DMG_W      = 16;
  localparam int unsigned VM_W       = 32;
  localparam int unsigned STR_W      = 32;
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned FRAC_W     = 12;
  localparam int unsigned SPAN_D_W   = 16;
  localparam int unsigned SPAN_S_W   = 32;
  localparam int unsigned WIN_W      = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned PROD_W     = COEF_W + STR_W;

  localparam logic signed [DMG_W-1:0] RST_DAMAGE_MID  = 16'sd8192;
  localparam logic signed [DMG_W-1:0] RST_DAMAGE_MAX  = 16'sd16384;
  localparam logic [COEF_W-1:0]       RST_LOW_COEFF   = 16'd2048;
  localparam logic [COEF_W-1:0]       RST_HIGH_COEFF  = 16'd2458;
  localparam logic [SPAN_D_W-1:0]     RST_DAMAGE_SPAN = 16'd819;
  localparam logic [SPAN_S_W-1:0]     RST_STRESS_SPAN = 32'd3000;
  localparam logic [WIN_W-1:0]        RST_DAMAGE_WIN  = 4'd5;
  localparam logic [WIN_W-1:0]        RST_STRESS_WIN  = 4'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DAMAGE_MID  = 3'd0,
    REG_DAMAGE_MAX  = 3'd1,
    REG_LOW_COEFF   = 3'd2,
    REG_HIGH_COEFF  = 3'd3,
    REG_DAMAGE_SPAN = 3'd4,
    REG_STRESS_SPAN = 3'd5,
    REG_DAMAGE_WIN  = 3'd6,
    REG_STRESS_WIN  = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [IDX_W-1:0]        element_index;
    logic signed [DMG_W-1:0] damage;
    logic [VM_W-1:0]         von_mises;
    logic [STR_W-1:0]        strength;
  } in_word_t;

  typedef struct packed {
    logic refine;
    logic damage_stable;
    logic stress_stable;
  } out_word_t;

  typedef struct packed {
    cfg_reg_e                index;
    logic [CFG_DATA_W-1:0]   data;
  } cfg_word_t;

  typedef struct packed {
    logic signed [DMG_W-1:0] damage_mid_limit;
    logic signed [DMG_W-1:0] damage_max_limit;
    logic [COEF_W-1:0]       low_stress_coeff;
    logic [COEF_W-1:0]       high_stress_coeff;
    logic [SPAN_D_W-1:0]     damage_span_limit;
    logic [SPAN_S_W-1:0]     stress_span_limit;
    logic [WIN_W-1:0]        damage_window;
    logic [WIN_W-1:0]        stress_window;
  } cfg_regs_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_UPDATE,
    ST_SCAN,
    ST_LAST,
    ST_RESULT
  } ctrl_state_e;

  typedef struct packed {
    logic clear_step;
    logic capture;
    logic reduce_step;
    logic meta_read;
    logic update;
    logic scan_read;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic reduce_done;
    logic single_read;
    logic scan_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

[rtl/wsrc_chan_if.sv]
`default_nettype none

interface wsrc_chan_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t word;

  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

`default_nettype wire

[rtl/wsrc_cfg.sv]
`default_nettype none

module wsrc_cfg (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     valid_i,
  input  wsrc_pkg::cfg_word_t     word_i,
  output logic                    ready_o,
  output wsrc_pkg::cfg_regs_t     regs_o
);

  wsrc_pkg::cfg_regs_t regs_q, regs_d;

  assign ready_o = 1'b1;
  assign regs_o  = regs_q;

  always_comb begin
    regs_d = regs_q;
    if (valid_i) begin
      unique case (word_i.index)
        wsrc_pkg::REG_DAMAGE_MID:  regs_d.damage_mid_limit  = $signed(word_i.data[15:0]);
        wsrc_pkg::REG_DAMAGE_MAX:  regs_d.damage_max_limit  = $signed(word_i.data[15:0]);
        wsrc_pkg::REG_LOW_COEFF:   regs_d.low_stress_coeff  = word_i.data[15:0];
        wsrc_pkg::REG_HIGH_COEFF:  regs_d.high_stress_coeff = word_i.data[15:0];
        wsrc_pkg::REG_DAMAGE_SPAN: regs_d.damage_span_limit = word_i.data[15:0];
        wsrc_pkg::REG_STRESS_SPAN: regs_d.stress_span_limit = word_i.data;
        wsrc_pkg::REG_DAMAGE_WIN:  regs_d.damage_window     = word_i.data[3:0];
        wsrc_pkg::REG_STRESS_WIN:  regs_d.stress_window     = word_i.data[3:0];
        default:                   regs_d = regs_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.damage_mid_limit  <= wsrc_pkg::RST_DAMAGE_MID;
      regs_q.damage_max_limit  <= wsrc_pkg::RST_DAMAGE_MAX;
      regs_q.low_stress_coeff  <= wsrc_pkg::RST_LOW_COEFF;
      regs_q.high_stress_coeff <= wsrc_pkg::RST_HIGH_COEFF;
      regs_q.damage_span_limit <= wsrc_pkg::RST_DAMAGE_SPAN;
      regs_q.stress_span_limit <= wsrc_pkg::RST_STRESS_SPAN;
      regs_q.damage_window     <= wsrc_pkg::RST_DAMAGE_WIN;
      regs_q.stress_window     <= wsrc_pkg::RST_STRESS_WIN;
    end else begin
      regs_q <= regs_d;
    end
  end

endmodule

`default_nettype wire

[rtl/wsrc_ctrl.sv]
`default_nettype none

module wsrc_ctrl (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_ready_o,
  input  wsrc_pkg::dp_status_t     status_i,
  output wsrc_pkg::dp_cmd_t        cmd_o
);

  wsrc_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wsrc_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      wsrc_pkg::ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (status_i.clear_last) state_d = wsrc_pkg::ST_IDLE;
      end
      wsrc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = wsrc_pkg::ST_REDUCE;
        end
      end
      wsrc_pkg::ST_REDUCE: begin
        // The index is folded into range first; the history lookup follows.
        if (status_i.reduce_done) begin
          cmd_o.meta_read = 1'b1;
          state_d         = wsrc_pkg::ST_UPDATE;
        end else begin
          cmd_o.reduce_step = 1'b1;
        end
      end
      wsrc_pkg::ST_UPDATE: begin
        cmd_o.update = 1'b1;
        if (status_i.single_read) state_d = wsrc_pkg::ST_RESULT;
        else                      state_d = wsrc_pkg::ST_SCAN;
      end
      wsrc_pkg::ST_SCAN: begin
        cmd_o.scan_read = 1'b1;
        if (status_i.scan_last) state_d = wsrc_pkg::ST_LAST;
      end
      wsrc_pkg::ST_LAST: begin
        state_d = wsrc_pkg::ST_RESULT;
      end
      wsrc_pkg::ST_RESULT: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = wsrc_pkg::ST_IDLE;
        end
      end
      default: state_d = wsrc_pkg::ST_CLEAR;
    endcase
  end

endmodule

`default_nettype wire

[rtl/wsrc_dpath.sv]
`default_nettype none

module wsrc_dpath #(
  parameter int unsigned ELEMENT_COUNT = 1024,
  parameter int unsigned WINDOW_MAX    = 8
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wsrc_pkg::dp_cmd_t        cmd_i,
  output wsrc_pkg::dp_status_t     status_o,
  input  wsrc_pkg::in_word_t       in_word_i,
  input  wsrc_pkg::cfg_regs_t      cfg_i,
  input  wire                      out_ready_i,
  output logic                     out_valid_o,
  output wsrc_pkg::out_word_t      out_word_o
);

  localparam int unsigned EW     = (ELEMENT_COUNT > 1) ? $clog2(ELEMENT_COUNT) : 1;
  localparam int unsigned SLW    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned FW     = $clog2(WINDOW_MAX + 1);
  localparam int unsigned CW     = (FW > wsrc_pkg::WIN_W) ? FW : wsrc_pkg::WIN_W;
  localparam int unsigned DEPTH  = ELEMENT_COUNT * WINDOW_MAX;
  localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned STEP_W = $clog2(wsrc_pkg::IDX_W);
  localparam int unsigned DIV_W  = $clog2(ELEMENT_COUNT + 1) + wsrc_pkg::IDX_W;
  localparam int unsigned META_W = SLW + FW;

  localparam int unsigned DMG_W  = wsrc_pkg::DMG_W;
  localparam int unsigned VM_W   = wsrc_pkg::VM_W;
  localparam int unsigned PROD_W = wsrc_pkg::PROD_W;

  function automatic logic [FW-1:0] clamp_win(input logic [wsrc_pkg::WIN_W-1:0] w);
    logic [CW-1:0] wx;
    wx = CW'(w);
    if (wx == '0) return FW'(1);
    if (wx > CW'(WINDOW_MAX)) return FW'(WINDOW_MAX);
    return FW'(wx);
  endfunction

  // Captured word and index reduction.
  logic [wsrc_pkg::IDX_W-1:0]    rem_q;
  logic [STEP_W-1:0]             step_q;
  logic signed [DMG_W-1:0]       dmg_q;
  logic [VM_W-1:0]               vm_q;
  logic [wsrc_pkg::STR_W-1:0]    str_q;
  logic [DIV_W-1:0]              sub_val;
  logic [EW-1:0]                 elem;

  // Per element ring position and fill count.
  logic [META_W-1:0]             meta_mem [ELEMENT_COUNT];
  logic [META_W-1:0]             meta_rd_q;
  logic [EW-1:0]                 clr_q;
  logic [SLW-1:0]                pos;
  logic [FW-1:0]                 fill;
  logic [SLW-1:0]                pos_next;
  logic [FW-1:0]                 fill_next;

  // Sample histories.
  logic [DMG_W-1:0]              dmg_mem [DEPTH];
  logic [VM_W-1:0]               vm_mem  [DEPTH];
  logic [DMG_W-1:0]              dmg_rd_q;
  logic [VM_W-1:0]               vm_rd_q;
  logic [AW-1:0]                 base_q;
  logic [AW-1:0]                 wr_addr;
  logic [AW-1:0]                 rd_addr;

  // Window scan.
  logic [FW-1:0]                 dw;
  logic [FW-1:0]                 sw;
  logic [FW-1:0]                 max_win;
  logic [FW-1:0]                 k_q;
  logic [FW-1:0]                 rd_k_q;
  logic                          rd_valid_q;
  logic [SLW-1:0]                slot_q;
  logic signed [DMG_W-1:0]       dlo_q, dhi_q;
  logic [VM_W-1:0]               slo_q, shi_q;
  logic                          d_full_q, s_full_q;

  // Stress limit and decision.
  logic [wsrc_pkg::COEF_W-1:0]   coeff_sel;
  logic                          mid_sel;
  logic [PROD_W-1:0]             prod_d, prod_q;
  logic                          mid_sel_q;
  logic                          force_q;
  logic signed [DMG_W:0]         dspan;
  logic [VM_W-1:0]               sspan;
  logic [PROD_W-1:0]             scaled;
  logic                          below;
  logic                          d_stable, s_stable;

  wsrc_pkg::out_word_t           out_word_q;
  logic                          out_valid_q;

  assign sub_val = DIV_W'(ELEMENT_COUNT) << step_q;
  assign elem    = EW'(rem_q);

  assign dw      = clamp_win(cfg_i.damage_window);
  assign sw      = clamp_win(cfg_i.stress_window);
  assign max_win = (dw > sw) ? dw : sw;

  assign pos       = meta_rd_q[META_W-1:FW];
  assign fill      = meta_rd_q[FW-1:0];
  assign pos_next  = (pos == SLW'(WINDOW_MAX - 1)) ? '0 : pos + SLW'(1);
  assign fill_next = (fill < FW'(WINDOW_MAX)) ? fill + FW'(1) : fill;

  assign wr_addr = base_q + AW'(pos);
  assign rd_addr = base_q + AW'(slot_q);

  assign mid_sel   = $signed(dmg_q) <= $signed(cfg_i.damage_mid_limit);
  assign coeff_sel = mid_sel ? cfg_i.low_stress_coeff : cfg_i.high_stress_coeff;
  assign prod_d    = PROD_W'(coeff_sel) * PROD_W'(str_q);

  assign dspan    = $signed({dhi_q[DMG_W-1], dhi_q}) - $signed({dlo_q[DMG_W-1], dlo_q});
  assign sspan    = shi_q - slo_q;
  assign d_stable = d_full_q && ($unsigned(dspan) < {1'b0, cfg_i.damage_span_limit});
  assign s_stable = s_full_q && (sspan < cfg_i.stress_span_limit);
  assign scaled   = PROD_W'({vm_q, {wsrc_pkg::FRAC_W{1'b0}}});
  assign below    = mid_sel_q ? (scaled <= prod_q) : (scaled < prod_q);

  assign status_o.clear_last  = (clr_q == EW'(ELEMENT_COUNT - 1));
  assign status_o.reduce_done = (DIV_W'(rem_q) < DIV_W'(ELEMENT_COUNT));
  assign status_o.single_read = (max_win == FW'(1));
  assign status_o.scan_last   = (k_q == max_win - FW'(1));
  assign status_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // Capture and restoring reduction of the element index.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      rem_q  <= in_word_i.element_index;
      step_q <= STEP_W'(wsrc_pkg::IDX_W - 1);
      dmg_q  <= in_word_i.damage;
      vm_q   <= in_word_i.von_mises;
      str_q  <= in_word_i.strength;
    end else if (cmd_i.reduce_step) begin
      if (DIV_W'(rem_q) >= sub_val) rem_q <= rem_q - wsrc_pkg::IDX_W'(sub_val);
      step_q <= step_q - STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear_step) begin
      clr_q <= clr_q + EW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_step) begin
      meta_mem[clr_q] <= '0;
    end else if (cmd_i.update) begin
      meta_mem[elem] <= {pos_next, fill_next};
    end
    if (cmd_i.meta_read) meta_rd_q <= meta_mem[elem];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      dmg_mem[wr_addr] <= dmg_q;
      vm_mem[wr_addr]  <= vm_q;
    end
    if (cmd_i.scan_read) begin
      dmg_rd_q <= dmg_mem[rd_addr];
      vm_rd_q  <= vm_mem[rd_addr];
    end
  end

  // The stress limit product is formed while the element state is fetched.
  always_ff @(posedge clk_i) begin
    if (cmd_i.meta_read) begin
      base_q    <= AW'(elem) * AW'(WINDOW_MAX);
      prod_q    <= prod_d;
      mid_sel_q <= mid_sel;
      force_q   <= $signed(dmg_q) > $signed(cfg_i.damage_max_limit);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= cmd_i.scan_read;
    end
  end

  // The newest sample seeds the extremes; older ones arrive one per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      d_full_q <= fill_next >= dw;
      s_full_q <= fill_next >= sw;
      dlo_q    <= dmg_q;
      dhi_q    <= dmg_q;
      slo_q    <= vm_q;
      shi_q    <= vm_q;
      k_q      <= FW'(1);
      slot_q   <= (pos == '0) ? SLW'(WINDOW_MAX - 1) : pos - SLW'(1);
    end else begin
      if (cmd_i.scan_read) begin
        rd_k_q <= k_q;
        k_q    <= k_q + FW'(1);
        slot_q <= (slot_q == '0) ? SLW'(WINDOW_MAX - 1) : slot_q - SLW'(1);
      end
      if (rd_valid_q) begin
        if (rd_k_q < dw) begin
          if ($signed(dmg_rd_q) < dlo_q) dlo_q <= $signed(dmg_rd_q);
          if ($signed(dmg_rd_q) > dhi_q) dhi_q <= $signed(dmg_rd_q);
        end
        if (rd_k_q < sw) begin
          if (vm_rd_q < slo_q) slo_q <= vm_rd_q;
          if (vm_rd_q > shi_q) shi_q <= vm_rd_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_word_q.refine        <= force_q || (!below && !(d_stable && s_stable));
      out_word_q.damage_stable <= d_stable;
      out_word_q.stress_stable <= s_stable;
    end
  end

endmodule

`default_nettype wire

[rtl/windowed_stability_refine_classifier_unit.sv]
// Flow: an accepted word is captured, its index folded into range, its element state fetched and
// its sample written; older history entries are then read one per cycle until the n newest, n being
// the larger of the two clamped window lengths, are covered, and the result word is loaded once the
// output register is free; no new word is taken before that load. When ELEMENT_COUNT is below 1024
// the index is folded by a restoring reduction. Reset: configuration takes its reset values and the
// output register empties; then a clearing pass zeroes per element ring positions and fill counts.
`default_nettype none

module windowed_stability_refine_classifier_unit #(
  parameter int unsigned ELEMENT_COUNT = 1024,
  parameter int unsigned WINDOW_MAX    = 8
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  wsrc_chan_if.sink    in_i,
  wsrc_chan_if.source  out_o,
  wsrc_chan_if.sink    cfg_i
);

  wsrc_pkg::dp_cmd_t    cmd;
  wsrc_pkg::dp_status_t status;
  wsrc_pkg::cfg_regs_t  regs;

  wsrc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cfg_i.valid),
    .word_i  (cfg_i.word),
    .ready_o (cfg_i.ready),
    .regs_o  (regs)
  );

  wsrc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  wsrc_dpath #(
    .ELEMENT_COUNT (ELEMENT_COUNT),
    .WINDOW_MAX    (WINDOW_MAX)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_word_i   (in_i.word),
    .cfg_i       (regs),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_word_o  (out_o.word)
  );

endmodule

`default_nettype wire

[rtl/wsrc_checker.sv]
`default_nettype none

module wsrc_checker (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  input  wire                   in_ready_i,
  input  wire                   out_valid_i,
  input  wire                   out_ready_i,
  input  wsrc_pkg::out_word_t   out_word_i
);

  // Words accepted but not yet delivered.
  logic [1:0] pend_q;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_acc && !out_acc) begin
      pend_q <= pend_q + 2'd1;
    end else if (out_acc && !in_acc) begin
      pend_q <= pend_q - 2'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_word_i))
    else $error("result word changed or dropped while stalled");

  a_ready_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i |-> pend_q <= 2'd1)
    else $error("input ready while a word is still being classified");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 2'd0)
    else $error("result word without an accepted input word");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !in_ready_i && !out_valid_i)
    else $error("handshake active during reset");

endmodule

bind windowed_stability_refine_classifier_unit wsrc_checker u_wsrc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_word_i  (out_o.word)
);

`default_nettype wire
